// ===== sv/pes_pkg.sv =====
package pes_pkg;

    // APB register window: five 32-bit registers at byte addresses 4*i
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_TIME_STEP   = 3'd0,
        REG_GRAVITY     = 3'd1,
        REG_DRAG        = 3'd2,
        REG_GROUND      = 3'd3,
        REG_RESTITUTION = 3'd4
    } pes_reg_t;

endpackage

// ===== sv/pes_cfg.sv =====
module pes_cfg
    import pes_pkg::*;
#(
    parameter int WORD_WIDTH = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    output logic [FRAC_BITS:0]            time_step,
    output logic [WORD_WIDTH-2:0]         gravity,
    output logic [WORD_WIDTH-2:0]         drag,
    output logic signed [WORD_WIDTH-1:0]  ground_level,
    output logic [FRAC_BITS:0]            restitution
);

    localparam int W = WORD_WIDTH;
    localparam int F = FRAC_BITS;

    // reset values, rounded to the nearest code: dt = 1/30 s, g = 9.8,
    // drag = 0.5, ground = -1.8, restitution = 0.6
    localparam int DT_RST   = ((1 << F) + 15) / 30;
    localparam int GRAV_RST = (98 * (1 << F) + 5) / 10;
    localparam int DRAG_RST = 1 << (F - 1);
    localparam int GND_RST  = -((18 * (1 << F) + 5) / 10);
    localparam int REST_RST = (6 * (1 << F) + 5) / 10;

    logic [F:0]            time_step_reg;
    logic [W-2:0]          gravity_reg;
    logic [W-2:0]          drag_reg;
    logic signed [W-1:0]   ground_level_reg;
    logic [F:0]            restitution_reg;
    logic                  wr_en;
    pes_reg_t              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = pes_reg_t'(paddr[4:2]);

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg    <= (F+1)'(DT_RST);
            gravity_reg      <= (W-1)'(GRAV_RST);
            drag_reg         <= (W-1)'(DRAG_RST);
            ground_level_reg <= W'(GND_RST);
            restitution_reg  <= (F+1)'(REST_RST);
        end else if (wr_en) begin
            case (reg_sel)
                REG_TIME_STEP:   time_step_reg    <= pwdata[F:0];
                REG_GRAVITY:     gravity_reg      <= pwdata[W-2:0];
                REG_DRAG:        drag_reg         <= pwdata[W-2:0];
                REG_GROUND:      ground_level_reg <= pwdata[W-1:0];
                REG_RESTITUTION: restitution_reg  <= pwdata[F:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_sel)
            REG_TIME_STEP:   prdata = APB_DATA_W'(time_step_reg);
            REG_GRAVITY:     prdata = APB_DATA_W'(gravity_reg);
            REG_DRAG:        prdata = APB_DATA_W'(drag_reg);
            REG_GROUND:      prdata = APB_DATA_W'(ground_level_reg);
            REG_RESTITUTION: prdata = APB_DATA_W'(restitution_reg);
            default:         prdata = '0;
        endcase
    end

    assign time_step    = time_step_reg;
    assign gravity      = gravity_reg;
    assign drag         = drag_reg;
    assign ground_level = ground_level_reg;
    assign restitution  = restitution_reg;

endmodule

// ===== sv/pes_vel.sv =====
module pes_vel #(
    parameter int WORD_WIDTH = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [FRAC_BITS:0]                    time_step,
    input  logic [WORD_WIDTH-2:0]                 gravity,
    input  logic [WORD_WIDTH-2:0]                 drag,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [WORD_WIDTH-1:0]          in_pos [3],
    input  logic signed [WORD_WIDTH-1:0]          in_vel [3],
    input  logic [WORD_WIDTH-2:0]                 in_life,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [WORD_WIDTH-1:0]          out_pos [3],
    output logic signed [WORD_WIDTH-1:0]          out_vel [3],
    output logic signed [WORD_WIDTH+FRAC_BITS+1:0] out_pdt [3],
    output logic [WORD_WIDTH-2:0]                 out_life
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int CW = (W - 1 > F + 1) ? W - 1 : F + 1;
    localparam int GW = W + F;
    localparam int SW = ((W > F + 1) ? W : F + 1) + 2;
    localparam int XW = 2 * W + F + 4;
    localparam int PW = W + F + 2;
    localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] x);
        logic signed [W-1:0] r;
        if (x > SAT_HI) begin
            r = SAT_HI[W-1:0];
        end else if (x < SAT_LO) begin
            r = SAT_LO[W-1:0];
        end else begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    // stage valid bits and advance enables (a stage moves when it is
    // empty or the next one moves)
    logic [3:0] vld_reg;
    logic [3:0] en;

    always_comb begin
        en[3] = !vld_reg[3] || out_ready;
        for (int k = 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[3];

    // stage 1: life decrement, g*dt and drag*dt
    logic                  keep;
    logic [W-2:0]          life1_next;
    logic [CW-1:0]         life_ext;
    logic [CW-1:0]         dt_ext;
    logic [GW-1:0]         gprod;
    logic [GW-1:0]         dprod;

    logic signed [W-1:0]   pos1_reg [3];
    logic signed [W-1:0]   vel1_reg [3];
    logic [W-2:0]          life1_reg;
    logic [W-1:0]          gdt1_reg;
    logic [W-1:0]          ddt1_reg;

    always_comb begin
        life_ext   = CW'(in_life);
        dt_ext     = CW'(time_step);
        keep       = life_ext > dt_ext;
        life1_next = (W-1)'(life_ext - dt_ext);
        gprod      = GW'(gravity) * GW'(time_step);
        dprod      = GW'(drag) * GW'(time_step);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pos1_reg  <= in_pos;
            vel1_reg  <= in_vel;
            life1_reg <= life1_next;
            gdt1_reg  <= gprod[GW-1:F];
            ddt1_reg  <= dprod[GW-1:F];
        end
    end

    // stage 2: gravity on vy, damping scale 1 - drag*dt
    logic signed [W+1:0]   vy_diff;
    logic signed [SW-1:0]  scale_diff;
    logic signed [W-1:0]   pos2_reg [3];
    logic signed [W-1:0]   vel2_reg [3];
    logic signed [W-1:0]   scale2_reg;
    logic [W-2:0]          life2_reg;

    always_comb begin
        vy_diff    = (W+2)'(vel1_reg[1]) - $signed({2'b00, gdt1_reg});
        scale_diff = $signed(SW'(1) << F) - $signed(SW'(ddt1_reg));
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pos2_reg    <= pos1_reg;
            vel2_reg[0] <= vel1_reg[0];
            vel2_reg[1] <= sat_w(XW'(vy_diff));
            vel2_reg[2] <= vel1_reg[2];
            scale2_reg  <= sat_w(XW'(scale_diff));
            life2_reg   <= life1_reg;
        end
    end

    // stage 3: velocity times scale
    logic signed [W-1:0]   pos3_reg [3];
    logic signed [2*W-1:0] vprod3_reg [3];
    logic [W-2:0]          life3_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            pos3_reg  <= pos2_reg;
            life3_reg <= life2_reg;
            for (int i = 0; i < 3; i++) begin
                vprod3_reg[i] <= vel2_reg[i] * scale2_reg;
            end
        end
    end

    // stage 4: saturate damped velocity, velocity times dt
    logic signed [W-1:0]   vel4_next [3];
    logic signed [PW-1:0]  pdt4_next [3];
    logic signed [PW-1:0]  dt_s;
    logic signed [W-1:0]   pos4_reg [3];
    logic signed [W-1:0]   vel4_reg [3];
    logic signed [PW-1:0]  pdt4_reg [3];
    logic [W-2:0]          life4_reg;

    always_comb begin
        dt_s = $signed(PW'(time_step));
        for (int i = 0; i < 3; i++) begin
            vel4_next[i] = sat_w(XW'(vprod3_reg[i] >>> F));
            pdt4_next[i] = PW'(vel4_next[i]) * dt_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            pos4_reg  <= pos3_reg;
            vel4_reg  <= vel4_next;
            pdt4_reg  <= pdt4_next;
            life4_reg <= life3_reg;
        end
    end

    // valid bits; a particle whose life runs out never enters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= in_valid && keep;
            for (int k = 1; k < 4; k++) begin
                if (en[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign out_pos  = pos4_reg;
    assign out_vel  = vel4_reg;
    assign out_pdt  = pdt4_reg;
    assign out_life = life4_reg;

`ifndef SYNTHESIS
    // an expired particle leaves no trace in the first stage
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && (CW'(in_life) <= CW'(time_step))) |=> !vld_reg[0])
        else $error("expired particle entered the pipeline");

    // back-pressure only when every stage is occupied and the output is held
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> ((&vld_reg) && !out_ready))
        else $error("input stalled with a free stage");

    // an item reaches the last stage only from the stage before
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(vld_reg[3]) |-> $past(vld_reg[2]))
        else $error("item appeared from nowhere");
`endif

endmodule

// ===== sv/pes_pos.sv =====
module pes_pos #(
    parameter int WORD_WIDTH = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [WORD_WIDTH-1:0]          ground_level,
    input  logic [FRAC_BITS:0]                    restitution,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [WORD_WIDTH-1:0]          in_pos [3],
    input  logic signed [WORD_WIDTH-1:0]          in_vel [3],
    input  logic signed [WORD_WIDTH+FRAC_BITS+1:0] in_pdt [3],
    input  logic [WORD_WIDTH-2:0]                 in_life,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [WORD_WIDTH-1:0]          out_pos [3],
    output logic signed [WORD_WIDTH-1:0]          out_vel [3],
    output logic [WORD_WIDTH-2:0]                 out_life
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int XW = 2 * W + F + 4;
    localparam int BW = W + F + 3;
    localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] x);
        logic signed [W-1:0] r;
        if (x > SAT_HI) begin
            r = SAT_HI[W-1:0];
        end else if (x < SAT_LO) begin
            r = SAT_LO[W-1:0];
        end else begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    logic [2:0] vld_reg;
    logic [2:0] en;

    always_comb begin
        en[2] = !vld_reg[2] || out_ready;
        for (int k = 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[2];

    // stage 5: position update, ground test and clamp
    logic signed [W-1:0]   pos5_next [3];
    logic                  below5_next;
    logic signed [W-1:0]   pos5_reg [3];
    logic signed [W-1:0]   vel5_reg [3];
    logic                  below5_reg;
    logic [W-2:0]          life5_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos5_next[i] = sat_w(XW'(in_pdt[i] >>> F) + XW'(in_pos[i]));
        end
        below5_next = pos5_next[1] < ground_level;
        if (below5_next) pos5_next[1] = ground_level;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pos5_reg   <= pos5_next;
            vel5_reg   <= in_vel;
            below5_reg <= below5_next;
            life5_reg  <= in_life;
        end
    end

    // stage 6: bounce product -vy * restitution
    logic signed [BW-1:0]  bprod6_next;
    logic signed [W-1:0]   pos6_reg [3];
    logic signed [W-1:0]   vel6_reg [3];
    logic signed [BW-1:0]  bprod6_reg;
    logic                  below6_reg;
    logic [W-2:0]          life6_reg;

    always_comb begin
        bprod6_next = (-BW'(vel5_reg[1])) * $signed(BW'(restitution));
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pos6_reg   <= pos5_reg;
            vel6_reg   <= vel5_reg;
            bprod6_reg <= bprod6_next;
            below6_reg <= below5_reg;
            life6_reg  <= life5_reg;
        end
    end

    // stage 7: pick the bounced vertical speed, output register
    logic signed [W-1:0]   pos7_reg [3];
    logic signed [W-1:0]   vel7_reg [3];
    logic [W-2:0]          life7_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            pos7_reg    <= pos6_reg;
            vel7_reg[0] <= vel6_reg[0];
            vel7_reg[1] <= below6_reg ? sat_w(XW'(bprod6_reg >>> F)) : vel6_reg[1];
            vel7_reg[2] <= vel6_reg[2];
            life7_reg   <= life6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= in_valid;
            for (int k = 1; k < 3; k++) begin
                if (en[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign out_pos  = pos7_reg;
    assign out_vel  = vel7_reg;
    assign out_life = life7_reg;

`ifndef SYNTHESIS
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> ((&vld_reg) && !out_ready))
        else $error("input stalled with a free stage");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(vld_reg[2]) |-> $past(vld_reg[1]))
        else $error("item appeared from nowhere");

    // only live particles come out
    a_life: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_life != '0))
        else $error("result with zero life");
`endif

endmodule

// ===== sv/particle_euler_step.sv =====
// Explicit Euler update of one particle per transaction. The block takes a
// new particle every clock cycle unless m_tready stalls the pipeline
// (four stages for life and velocity, three for position and ground bounce;
// no path through a stage passes more than one multiplier). Particles whose
// life drops to zero or below are dropped in the first stage and give no
// output transaction. Back-pressure on m_tready stalls the pipeline stage by
// stage, so s_tready stays high while any stage is free. Registers are
// written over APB at byte address 4*i (time_step, gravity, drag,
// ground_level, restitution) and should only be changed while no particle
// is in flight.
module particle_euler_step
    import pes_pkg::*;
#(
    parameter int WORD_WIDTH = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    // particle in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_left, zero pad
    input  logic [((7*WORD_WIDTH-1+7)/8)*8-1:0] s_tdata,
    // particle out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    // new_life, zero pad
    output logic [((7*WORD_WIDTH-1+7)/8)*8-1:0] m_tdata
);

    localparam int W      = WORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int DATA_W = ((7*W-1+7)/8)*8;

    logic [F:0]            time_step;
    logic [W-2:0]          gravity;
    logic [W-2:0]          drag;
    logic signed [W-1:0]   ground_level;
    logic [F:0]            restitution;

    logic signed [W-1:0]   s_pos [3];
    logic signed [W-1:0]   s_vel [3];
    logic [W-2:0]          s_life;

    logic                  mid_valid;
    logic                  mid_ready;
    logic signed [W-1:0]   mid_pos [3];
    logic signed [W-1:0]   mid_vel [3];
    logic signed [W+F+1:0] mid_pdt [3];
    logic [W-2:0]          mid_life;

    logic signed [W-1:0]   m_pos [3];
    logic signed [W-1:0]   m_vel [3];
    logic [W-2:0]          m_life;

    // unpack the input transaction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_pos[i] = s_tdata[i*W +: W];
            s_vel[i] = s_tdata[(3+i)*W +: W];
        end
        s_life = s_tdata[6*W +: W-1];
    end

    pes_cfg #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (F)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .time_step    (time_step),
        .gravity      (gravity),
        .drag         (drag),
        .ground_level (ground_level),
        .restitution  (restitution)
    );

    pes_vel #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (F)
    ) u_vel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .time_step (time_step),
        .gravity   (gravity),
        .drag      (drag),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pos    (s_pos),
        .in_vel    (s_vel),
        .in_life   (s_life),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_pos   (mid_pos),
        .out_vel   (mid_vel),
        .out_pdt   (mid_pdt),
        .out_life  (mid_life)
    );

    pes_pos #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (F)
    ) u_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ground_level (ground_level),
        .restitution  (restitution),
        .in_valid     (mid_valid),
        .in_ready     (mid_ready),
        .in_pos       (mid_pos),
        .in_vel       (mid_vel),
        .in_pdt       (mid_pdt),
        .in_life      (mid_life),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_pos      (m_pos),
        .out_vel      (m_vel),
        .out_life     (m_life)
    );

    // pack the output transaction
    assign m_tdata = DATA_W'({m_life, m_vel[2], m_vel[1], m_vel[0],
                              m_pos[2], m_pos[1], m_pos[0]});

endmodule

// ===== bench/particle_euler_step_test.sv =====
module particle_euler_step_test;
    import pes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W      = 24;
    localparam int FRAC_W      = 16;
    localparam int TDATA_W     = ((7*WORD_W-1+7)/8)*8;
    localparam int REG_SLOTS   = 2**(APB_ADDR_W-2);
    localparam int SETTLE_CYC  = 20;
    localparam int HOLD_CYCLES = 120;
    localparam longint Q_MAX   = (64'sd1 <<< (WORD_W-1)) - 1;
    localparam longint Q_MIN   = -Q_MAX - 1;
    localparam longint ONE_Q   = 64'sd1 <<< FRAC_W;
    localparam longint LIFE_MAX = (64'sd1 <<< (WORD_W-1)) - 1;

    // one particle, first field in the lowest bits
    typedef struct packed {
        logic        [22:0] life;
        logic signed [23:0] vz;
        logic signed [23:0] vy;
        logic signed [23:0] vx;
        logic signed [23:0] pz;
        logic signed [23:0] py;
        logic signed [23:0] px;
    } particle_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_left, zero pad
    logic [TDATA_W-1:0]    s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    // new_life, zero pad
    logic [TDATA_W-1:0]    m_tdata;

    // register copy used by the predictor
    logic        [16:0] cfg_dt          = 17'd2185;
    logic        [22:0] cfg_gravity     = 23'd642253;
    logic        [22:0] cfg_drag        = 23'd32768;
    logic signed [23:0] cfg_ground      = -24'sd117965;
    logic        [16:0] cfg_restitution = 17'd39322;

    particle_t pending_particles[$];
    int        errors        = 0;
    bit        steady        = 1'b0;
    int        hold_requests = 0;

    particle_euler_step dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint sat_q(input longint x);
        if (x > Q_MAX) return Q_MAX;
        if (x < Q_MIN) return Q_MIN;
        return x;
    endfunction

    // floor shift of a fixed-point product
    function automatic longint frac_shift(input longint x);
        return x >>> FRAC_W;
    endfunction

    // one Euler step; returns 0 when the particle has run out of life
    function automatic bit advance_particle(input particle_t p, output particle_t r);
        longint pos[3];
        longint vel[3];
        longint dt;
        longint life;
        longint scale;
        dt     = longint'(cfg_dt);
        pos[0] = longint'($signed(p.px));
        pos[1] = longint'($signed(p.py));
        pos[2] = longint'($signed(p.pz));
        vel[0] = longint'($signed(p.vx));
        vel[1] = longint'($signed(p.vy));
        vel[2] = longint'($signed(p.vz));
        r      = '0;
        life   = longint'(p.life) - dt;
        if (life <= 0) return 1'b0;

        vel[1] = sat_q(vel[1] - frac_shift(longint'(cfg_gravity) * dt));
        scale  = sat_q(ONE_Q - frac_shift(longint'(cfg_drag) * dt));
        for (int i = 0; i < 3; i++) vel[i] = sat_q(frac_shift(vel[i] * scale));
        for (int i = 0; i < 3; i++) pos[i] = sat_q(pos[i] + frac_shift(vel[i] * dt));

        // ground bounce
        if (pos[1] < longint'(cfg_ground)) begin
            pos[1] = longint'(cfg_ground);
            vel[1] = sat_q(frac_shift(-vel[1] * longint'(cfg_restitution)));
        end

        r.px   = pos[0][23:0];
        r.py   = pos[1][23:0];
        r.pz   = pos[2][23:0];
        r.vx   = vel[0][23:0];
        r.vy   = vel[1][23:0];
        r.vz   = vel[2][23:0];
        r.life = life[22:0];
        return 1'b1;
    endfunction

    function automatic int spread(input int span);
        return int'($urandom_range(0, 2*span)) - span;
    endfunction

    function automatic particle_t make_particle(input longint px, input longint py,
                                                input longint pz, input longint vx,
                                                input longint vy, input longint vz,
                                                input longint life);
        particle_t p;
        p.px   = px[23:0];
        p.py   = py[23:0];
        p.pz   = pz[23:0];
        p.vx   = vx[23:0];
        p.vy   = vy[23:0];
        p.vz   = vz[23:0];
        p.life = life[22:0];
        return p;
    endfunction

    // mostly plausible particles near the ground, some raw bit patterns
    function automatic particle_t random_particle();
        particle_t p;
        longint    life;
        int        kind;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            p.px = 24'($urandom()); p.py = 24'($urandom()); p.pz = 24'($urandom());
            p.vx = 24'($urandom()); p.vy = 24'($urandom()); p.vz = 24'($urandom());
            p.life = 23'($urandom());
        end else begin
            if (kind < 25)
                life = longint'($urandom_range(0, cfg_dt));
            else
                life = longint'(cfg_dt) + 1 + longint'($urandom_range(0, 8 << FRAC_W));
            if (life > LIFE_MAX) life = LIFE_MAX;
            p = make_particle(spread(4 << FRAC_W),
                              sat_q(longint'(cfg_ground) + spread(2 << FRAC_W)),
                              spread(4 << FRAC_W), spread(16 << FRAC_W),
                              spread(16 << FRAC_W), spread(16 << FRAC_W), life);
        end
        return p;
    endfunction

    function automatic bit sender_idles();
        return !steady && ($urandom_range(0, 99) < 24);
    endfunction

    // append one expected update to the scoreboard
    function automatic void record_expected(input particle_t p);
        pending_particles.insert(pending_particles.size(), p);
    endfunction

    // offer one particle and record its expected update once it is taken
    task automatic send_particle(input particle_t p);
        particle_t upd;
        @(negedge aclk);
        while (sender_idles()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, p};
        do @(posedge aclk); while (!s_tready);
        if (advance_particle(p, upd)) record_expected(upd);
    endtask

    // stop offering, wait for every result, then let dropped particles clear
    task automatic settle_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_particles.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic apb_write(input int index, input logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(index * 4);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            REG_TIME_STEP:   cfg_dt          = value[16:0];
            REG_GRAVITY:     cfg_gravity     = value[22:0];
            REG_DRAG:        cfg_drag        = value[22:0];
            REG_GROUND:      cfg_ground      = value[23:0];
            REG_RESTITUTION: cfg_restitution = value[16:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_settings(input logic [31:0] dt, input logic [31:0] grav,
                                  input logic [31:0] drag, input logic [31:0] ground,
                                  input logic [31:0] rest);
        apb_write(REG_TIME_STEP, dt);
        apb_write(REG_GRAVITY, grav);
        apb_write(REG_DRAG, drag);
        apb_write(REG_GROUND, ground);
        apb_write(REG_RESTITUTION, rest);
    endtask

    // field extremes, life boundaries and bounces with the reset settings
    task automatic test_reset_settings();
        longint dt;
        dt = longint'(cfg_dt);
        send_particle(make_particle(0, ONE_Q, 0, ONE_Q, 0, -ONE_Q, ONE_Q));
        send_particle(make_particle(ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0));
        send_particle(make_particle(ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, dt));
        send_particle(make_particle(ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, dt + 1));
        send_particle(make_particle(0, 0, 0, 0, 0, 0, LIFE_MAX));
        send_particle(make_particle(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, LIFE_MAX));
        send_particle(make_particle(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, LIFE_MAX));
        send_particle(make_particle(0, cfg_ground, 0, 0, -5 * ONE_Q, 0, ONE_Q));
        send_particle(make_particle(Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, 2 * ONE_Q));
        send_particle(make_particle(-1, -1, -1, -1, -1, -1, dt + 2));
        settle_pipeline();
    endtask

    // registers at and beyond their ranges, and writes to unused slots
    task automatic test_register_extremes();
        write_settings(0, 0, 0, 0, 0);
        send_particle(make_particle(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 0));
        send_particle(make_particle(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1));
        settle_pipeline();

        // every bit set: dt above one second, gravity at its maximum
        write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h0080_0000, 32'h0001_0000);
        send_particle(make_particle(0, 0, 0, ONE_Q, ONE_Q, ONE_Q, LIFE_MAX));
        send_particle(make_particle(Q_MAX, 0, Q_MIN, Q_MAX, Q_MIN, Q_MIN, LIFE_MAX));
        settle_pipeline();

        // huge drag turns the scale negative and reverses the velocity
        write_settings(32'h0001_0000, 0, 32'h007F_FFFF, 32'h0000_0000, 32'h0001_FFFF);
        send_particle(make_particle(0, ONE_Q, 0, ONE_Q, -ONE_Q, 3 * ONE_Q, LIFE_MAX));
        send_particle(make_particle(0, 0, 0, Q_MAX, Q_MIN, -1, LIFE_MAX));
        settle_pipeline();

        // ground at the top: every particle bounces, restitution above one
        write_settings(2185, 642253, 32768, 32'h007F_FFFF, 32'h0001_FFFF);
        send_particle(make_particle(0, 0, 0, 0, 7 * ONE_Q, 0, ONE_Q));
        send_particle(make_particle(0, Q_MIN, 0, Q_MAX, Q_MIN, Q_MIN, ONE_Q));
        settle_pipeline();

        // unused register slots must leave the settings alone
        for (int i = REG_RESTITUTION + 1; i < REG_SLOTS; i++) apb_write(i, 32'hFFFF_FFFF);
        send_particle(make_particle(ONE_Q, ONE_Q, 0, ONE_Q, ONE_Q, 0, ONE_Q));
        settle_pipeline();
    endtask

    // random settings per phase, random particles within each
    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++) begin
            if (phase % 2 == 0)
                write_settings($urandom_range(1, 6554), $urandom_range(0, 20 << FRAC_W),
                               $urandom_range(0, 2 << FRAC_W), spread(4 << FRAC_W),
                               $urandom_range(0, 1 << FRAC_W));
            else
                write_settings($urandom_range(0, 1 << FRAC_W), $urandom(), $urandom(),
                               $urandom(), $urandom_range(0, 1 << FRAC_W));
            steady = (phase == 2);
            for (int n = 0; n < 60; n++) send_particle(random_particle());
            settle_pipeline();
            steady = 1'b0;
        end
    endtask

    // receiver holds off while particles keep coming
    task automatic test_back_pressure();
        write_settings(2185, 642253, 32768, -117965, 39322);
        steady = 1'b1;
        hold_requests++;
        for (int n = 0; n < 70; n++) send_particle(random_particle());
        steady = 1'b0;
        settle_pipeline();
    endtask

    // result side: random stalls, or a long hold when asked
    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        forever begin
            @(negedge aclk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= 24);
            end
        end
    end

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // compare each output transaction with the oldest expected update
    always @(posedge aclk) begin
        particle_t want;
        particle_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[TDATA_W-2:0];
            if (pending_particles.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none actual %h",
                         $time, m_tdata);
            end else begin
                want = pending_particles.pop_front();
                check_field("new_pos_x", want.px, got.px);
                check_field("new_pos_y", want.py, got.py);
                check_field("new_pos_z", want.pz, got.pz);
                check_field("new_vel_x", want.vx, got.vx);
                check_field("new_vel_y", want.vy, got.vy);
                check_field("new_vel_z", want.vz, got.vz);
                check_field("new_life", 24'(want.life), 24'(got.life));
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_settings();
        test_register_extremes();
        test_random_phases();
        test_back_pressure();
        if (errors == 0)
            $display("particle_euler_step_test: PASS");
        else
            $display("particle_euler_step_test: FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("particle_euler_step_test: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pes_pkg.sv
sv/pes_cfg.sv
sv/pes_vel.sv
sv/pes_pos.sv
sv/particle_euler_step.sv
bench/particle_euler_step_test.sv
